/* design/lr_pkg.sv */
`timescale 1ns / 1ps

package lr_pkg;

	localparam int COORD_W = 6;
	localparam int AREA_W  = 7;
	localparam int ERR_W   = 9;
	localparam int GLYPH_W = 16;
	localparam int PAINT_W = 8;

	// depth of the command queue between classifier and walker
	localparam int QDEPTH  = 2;

	localparam logic [AREA_W-1:0] AREA_RESET = AREA_W'(64);

	// register addresses, paddr[2] selects
	localparam logic REG_AREA_WIDTH  = 1'b0;
	localparam logic REG_AREA_HEIGHT = 1'b1;

	// one classified line, normalised to major / minor axis
	typedef struct packed {
		logic                steep;
		logic [COORD_W-1:0]  maj;
		logic [COORD_W-1:0]  maj_end;
		logic [COORD_W-1:0]  min;
		logic                min_up;
		logic [COORD_W-1:0]  dmaj;
		logic [COORD_W-1:0]  dmin;
		logic [ERR_W-1:0]    err0;
		logic [GLYPH_W-1:0]  glyph;
		logic [PAINT_W-1:0]  paint;
	} line_cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_WALK = 2'b10
	} walk_state_t;

endpackage

/* design/line_rasterizer.sv */
`timescale 1ns / 1ps
// A request is queued, then loaded into the walker; each point is registered on the outputs.
// A line has N points (N = longer axis span + 1, at most COORD_RANGE); the walker
// steps one point per cycle, and queued lines follow each other with no gap.
// busy is high while the two-entry command queue is full; the receiver cannot stall results.
// Reset (arst_n low): area_width and area_height return to 64, queue and walker empty.

module line_rasterizer #(
	parameter int COORD_RANGE = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [lr_pkg::COORD_W-1:0]   start_x,
	input  logic [lr_pkg::COORD_W-1:0]   start_y,
	input  logic [lr_pkg::COORD_W-1:0]   end_x,
	input  logic [lr_pkg::COORD_W-1:0]   end_y,
	input  logic [lr_pkg::GLYPH_W-1:0]   glyph,
	input  logic [lr_pkg::PAINT_W-1:0]   paint,
	output logic                         point_strobe,
	output logic [lr_pkg::COORD_W-1:0]   point_x,
	output logic [lr_pkg::COORD_W-1:0]   point_y,
	output logic                         visible,
	output logic [lr_pkg::GLYPH_W-1:0]   point_glyph,
	output logic [lr_pkg::PAINT_W-1:0]   point_paint,
	output logic                         final_point,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [2:0]                   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);
	import lr_pkg::*;

	logic [AREA_W-1:0] area_width_q, area_height_q;
	line_cmd_t         front_cmd, head_cmd;
	logic              q_push, q_pop, q_empty, q_full, cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == REG_AREA_HEIGHT) ? {25'd0, area_height_q}
	                                              : {25'd0, area_width_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			area_width_q  <= AREA_RESET;
			area_height_q <= AREA_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_AREA_WIDTH:  area_width_q  <= pwdata[AREA_W-1:0];
				REG_AREA_HEIGHT: area_height_q <= pwdata[AREA_W-1:0];
				default:         area_width_q  <= area_width_q;
			endcase
		end
	end

	assign busy   = q_full;
	assign q_push = start && !q_full;

	lr_front #(
		.COORD_RANGE (COORD_RANGE)
	) u_front (
		.start_x (start_x),
		.start_y (start_y),
		.end_x   (end_x),
		.end_y   (end_y),
		.glyph   (glyph),
		.paint   (paint),
		.cmd     (front_cmd)
	);

	lr_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wr_cmd (front_cmd),
		.pop    (q_pop),
		.rd_cmd (head_cmd),
		.empty  (q_empty),
		.full   (q_full)
	);

	lr_walker u_walker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (head_cmd),
		.cmd_avail    (!q_empty),
		.cmd_pop      (q_pop),
		.area_width   (area_width_q),
		.area_height  (area_height_q),
		.point_strobe (point_strobe),
		.point_x      (point_x),
		.point_y      (point_y),
		.visible      (visible),
		.point_glyph  (point_glyph),
		.point_paint  (point_paint),
		.final_point  (final_point)
	);

endmodule

/* design/lr_front.sv */
`timescale 1ns / 1ps

module lr_front #(
	parameter int COORD_RANGE = 64
) (
	input  logic [lr_pkg::COORD_W-1:0] start_x,
	input  logic [lr_pkg::COORD_W-1:0] start_y,
	input  logic [lr_pkg::COORD_W-1:0] end_x,
	input  logic [lr_pkg::COORD_W-1:0] end_y,
	input  logic [lr_pkg::GLYPH_W-1:0] glyph,
	input  logic [lr_pkg::PAINT_W-1:0] paint,
	output lr_pkg::line_cmd_t          cmd
);
	import lr_pkg::*;

	localparam logic [COORD_W-1:0] CMAX = COORD_W'(COORD_RANGE - 1);

	logic [COORD_W-1:0] x1, y1, x2, y2;
	logic [COORD_W:0]   dx, dy;
	logic [COORD_W-1:0] adx, ady;
	logic               same_dir, steep, fwd;

	always_comb begin
		x1 = (start_x > CMAX) ? CMAX : start_x;
		y1 = (start_y > CMAX) ? CMAX : start_y;
		x2 = (end_x > CMAX) ? CMAX : end_x;
		y2 = (end_y > CMAX) ? CMAX : end_y;

		dx  = {1'b0, x2} - {1'b0, x1};
		dy  = {1'b0, y2} - {1'b0, y1};
		adx = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
		ady = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];

		same_dir = (dx[COORD_W] && dy[COORD_W]) ||
		           (!dx[COORD_W] && dx != '0 && !dy[COORD_W] && dy != '0);
		steep    = ady > adx;
		fwd      = steep ? !dy[COORD_W] : !dx[COORD_W];

		cmd.steep  = steep;
		cmd.min_up = same_dir;
		if (steep) begin
			cmd.maj     = fwd ? y1 : y2;
			cmd.maj_end = fwd ? y2 : y1;
			cmd.min     = fwd ? x1 : x2;
			cmd.dmaj    = ady;
			cmd.dmin    = adx;
		end else begin
			cmd.maj     = fwd ? x1 : x2;
			cmd.maj_end = fwd ? x2 : x1;
			cmd.min     = fwd ? y1 : y2;
			cmd.dmaj    = adx;
			cmd.dmin    = ady;
		end
		cmd.err0  = {2'b00, cmd.dmin, 1'b0} - {3'b000, cmd.dmaj};
		cmd.glyph = glyph;
		cmd.paint = paint;
	end

endmodule

/* design/lr_queue.sv */
`timescale 1ns / 1ps

module lr_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  lr_pkg::line_cmd_t  wr_cmd,
	input  logic               pop,
	output lr_pkg::line_cmd_t  rd_cmd,
	output logic               empty,
	output logic               full
);
	import lr_pkg::*;

	localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

	line_cmd_t      mem_q [QDEPTH];
	logic [AW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [AW:0]    count_q;

	assign empty  = (count_q == '0);
	assign full   = (count_q == (AW+1)'(QDEPTH));
	assign rd_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |-> !full)
		else $error("request pushed into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from empty queue");
`endif

endmodule

/* design/lr_walker.sv */
`timescale 1ns / 1ps

module lr_walker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  lr_pkg::line_cmd_t            cmd,
	input  logic                         cmd_avail,
	output logic                         cmd_pop,
	input  logic [lr_pkg::AREA_W-1:0]    area_width,
	input  logic [lr_pkg::AREA_W-1:0]    area_height,
	output logic                         point_strobe,
	output logic [lr_pkg::COORD_W-1:0]   point_x,
	output logic [lr_pkg::COORD_W-1:0]   point_y,
	output logic                         visible,
	output logic [lr_pkg::GLYPH_W-1:0]   point_glyph,
	output logic [lr_pkg::PAINT_W-1:0]   point_paint,
	output logic                         final_point
);
	import lr_pkg::*;

	walk_state_t         state_q;
	logic                steep_q, min_up_q;
	logic [COORD_W-1:0]  maj_q, maj_end_q, min_q;
	logic [ERR_W-1:0]    err_q, inc_keep_q, inc_move_q;
	logic [GLYPH_W-1:0]  glyph_q;
	logic [PAINT_W-1:0]  paint_q;

	logic                last, move, walking;
	logic [COORD_W-1:0]  cur_x, cur_y;

	logic                strobe_q, vis_q, final_q;
	logic [COORD_W-1:0]  px_q, py_q;
	logic [GLYPH_W-1:0]  pg_q;
	logic [PAINT_W-1:0]  pp_q;

	always_comb begin
		walking = (state_q == ST_WALK);
		last    = (maj_q == maj_end_q);
		// shallow lines step on err >= 0, steep ones only on err > 0
		move    = steep_q ? (!err_q[ERR_W-1] && err_q != '0) : !err_q[ERR_W-1];
		cmd_pop = cmd_avail && (!walking || last);
		cur_x   = steep_q ? min_q : maj_q;
		cur_y   = steep_q ? maj_q : min_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd_avail) state_q <= ST_WALK;
				end
				ST_WALK: begin
					if (last && !cmd_avail) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			steep_q    <= cmd.steep;
			min_up_q   <= cmd.min_up;
			maj_q      <= cmd.maj;
			maj_end_q  <= cmd.maj_end;
			min_q      <= cmd.min;
			err_q      <= cmd.err0;
			inc_keep_q <= {2'b00, cmd.dmin, 1'b0};
			inc_move_q <= {2'b00, cmd.dmin, 1'b0} - {2'b00, cmd.dmaj, 1'b0};
			glyph_q    <= cmd.glyph;
			paint_q    <= cmd.paint;
		end else if (walking) begin
			maj_q <= maj_q + 1'b1;
			if (move) begin
				min_q <= min_up_q ? min_q + 1'b1 : min_q - 1'b1;
				err_q <= err_q + inc_move_q;
			end else begin
				err_q <= err_q + inc_keep_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= walking;
		end
	end

	always_ff @(posedge clk) begin
		if (walking) begin
			px_q    <= cur_x;
			py_q    <= cur_y;
			vis_q   <= ({1'b0, cur_x} < area_width) && ({1'b0, cur_y} < area_height);
			pg_q    <= glyph_q;
			pp_q    <= paint_q;
			final_q <= last;
		end
	end

	assign point_strobe = strobe_q;
	assign point_x      = px_q;
	assign point_y      = py_q;
	assign visible      = vis_q;
	assign point_glyph  = pg_q;
	assign point_paint  = pp_q;
	assign final_point  = final_q;

`ifndef SYNTHESIS
	a_walk_emits: assert property (@(posedge clk) disable iff (!arst_n)
		walking |=> point_strobe)
		else $error("walk cycle without a point");
	a_walk_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		walking |-> maj_q <= maj_end_q)
		else $error("walk overran the end point");
`endif

endmodule

/* verif/line_rasterizer_checker.sv */
`timescale 1ns / 1ps

module line_rasterizer_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic                         busy,
	input  logic [lr_pkg::COORD_W-1:0]   start_x,
	input  logic [lr_pkg::COORD_W-1:0]   start_y,
	input  logic [lr_pkg::COORD_W-1:0]   end_x,
	input  logic [lr_pkg::COORD_W-1:0]   end_y,
	input  logic [lr_pkg::GLYPH_W-1:0]   glyph,
	input  logic [lr_pkg::PAINT_W-1:0]   paint,
	input  logic                         point_strobe,
	input  logic [lr_pkg::COORD_W-1:0]   point_x,
	input  logic [lr_pkg::COORD_W-1:0]   point_y,
	input  logic                         visible,
	input  logic [lr_pkg::GLYPH_W-1:0]   point_glyph,
	input  logic [lr_pkg::PAINT_W-1:0]   point_paint,
	input  logic                         final_point,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [2:0]                   paddr,
	input  logic [31:0]                  pwdata,
	input  logic [31:0]                  prdata,
	input  logic                         pready,
	output int                           pending,
	output int                           failures
);

	import lr_pkg::*;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic               vis;
		logic [GLYPH_W-1:0] glyph;
		logic [PAINT_W-1:0] paint;
		logic               last;
	} line_point_t;

	logic [AREA_W-1:0] area_cols;
	logic [AREA_W-1:0] area_rows;
	line_point_t expected_points[$];

	initial begin
		pending  = 0;
		failures = 0;
	end

	function automatic line_point_t make_point(int x, int y, logic [GLYPH_W-1:0] g,
			logic [PAINT_W-1:0] p, logic last);
		line_point_t pt;
		pt.x     = COORD_W'(x);
		pt.y     = COORD_W'(y);
		pt.vis   = (x < int'(area_cols)) && (y < int'(area_rows));
		pt.glyph = g;
		pt.paint = p;
		pt.last  = last;
		return pt;
	endfunction

	// Midpoint-error walk from the lower end of the major axis; queues every point.
	task automatic trace_line(int x1, int y1, int x2, int y2,
			logic [GLYPH_W-1:0] g, logic [PAINT_W-1:0] p);
		int dx, dy, adx, ady, err, x, y, stop_at, step;
		dx  = x2 - x1;
		dy  = y2 - y1;
		adx = dx < 0 ? -dx : dx;
		ady = dy < 0 ? -dy : dy;
		step = ((dx < 0 && dy < 0) || (dx > 0 && dy > 0)) ? 1 : -1;
		if (ady <= adx) begin
			err = 2 * ady - adx;
			if (dx >= 0) begin
				x = x1; y = y1; stop_at = x2;
			end else begin
				x = x2; y = y2; stop_at = x1;
			end
			expected_points.push_back(make_point(x, y, g, p, x >= stop_at));
			while (x < stop_at) begin
				x++;
				if (err < 0) begin
					err += 2 * ady;
				end else begin
					y += step;
					err += 2 * (ady - adx);
				end
				expected_points.push_back(make_point(x, y, g, p, x >= stop_at));
			end
		end else begin
			// steep: minor step only on a strictly positive error
			err = 2 * adx - ady;
			if (dy >= 0) begin
				x = x1; y = y1; stop_at = y2;
			end else begin
				x = x2; y = y2; stop_at = y1;
			end
			expected_points.push_back(make_point(x, y, g, p, y >= stop_at));
			while (y < stop_at) begin
				y++;
				if (err <= 0) begin
					err += 2 * adx;
				end else begin
					x += step;
					err += 2 * (adx - ady);
				end
				expected_points.push_back(make_point(x, y, g, p, y >= stop_at));
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		line_point_t got, want;
		logic [AREA_W-1:0] held;
		if (!arst_n) begin
			area_cols = AREA_RESET;
			area_rows = AREA_RESET;
			expected_points.delete();
			pending = 0;
		end else begin
			if (point_strobe) begin
				got = '{point_x, point_y, visible, point_glyph, point_paint, final_point};
				if (expected_points.size() == 0) begin
					failures++;
					if (failures <= 10)
						$display("unexpected point x=%0d y=%0d vis=%0b glyph=%h paint=%h last=%0b",
							got.x, got.y, got.vis, got.glyph, got.paint, got.last);
				end else begin
					want = expected_points.pop_front();
					if (got !== want) begin
						failures++;
						if (failures <= 10)
							$display("point mismatch: exp x=%0d y=%0d vis=%0b glyph=%h paint=%h last=%0b / got x=%0d y=%0d vis=%0b glyph=%h paint=%h last=%0b",
								want.x, want.y, want.vis, want.glyph, want.paint, want.last,
								got.x, got.y, got.vis, got.glyph, got.paint, got.last);
					end
				end
			end
			if (start && !busy)
				trace_line(int'(start_x), int'(start_y), int'(end_x), int'(end_y), glyph, paint);
			if (psel && penable && pready) begin
				if (pwrite) begin
					if (paddr[2] == REG_AREA_WIDTH)
						area_cols = pwdata[AREA_W-1:0];
					else
						area_rows = pwdata[AREA_W-1:0];
				end else begin
					held = (paddr[2] == REG_AREA_WIDTH) ? area_cols : area_rows;
					if (prdata[AREA_W-1:0] !== held) begin
						failures++;
						if (failures <= 10)
							$display("register read mismatch at %0d: exp %0d got %0d",
								paddr, held, prdata[AREA_W-1:0]);
					end
				end
			end
			pending = expected_points.size();
		end
	end

endmodule

/* verif/line_rasterizer_test.sv */
`timescale 1ns / 1ps

module line_rasterizer_test;

	import lr_pkg::*;

	localparam int STALL_LIMIT = 3000;
	localparam int PHASE_LINES = 77;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [COORD_W-1:0] start_x = '0;
	logic [COORD_W-1:0] start_y = '0;
	logic [COORD_W-1:0] end_x = '0;
	logic [COORD_W-1:0] end_y = '0;
	logic [GLYPH_W-1:0] glyph = '0;
	logic [PAINT_W-1:0] paint = '0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;

	logic busy, point_strobe, visible, final_point, pready;
	logic [COORD_W-1:0] point_x, point_y;
	logic [GLYPH_W-1:0] point_glyph;
	logic [PAINT_W-1:0] point_paint;
	logic [31:0] prdata;

	int pending, failures;
	int idle_pct = 0;
	int quiet_cycles = 0;

	line_rasterizer dut (.*);

	line_rasterizer_checker checker_i (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// watchdog: cycles with no request, no point and no register access
	always @(posedge clk) begin
		if ((start && !busy) || point_strobe || (psel && penable))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("line_rasterizer test failed");
			$finish;
		end
	end

	task automatic send_line(logic [COORD_W-1:0] sx, logic [COORD_W-1:0] sy,
			logic [COORD_W-1:0] ex, logic [COORD_W-1:0] ey,
			logic [GLYPH_W-1:0] g, logic [PAINT_W-1:0] p);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start   <= 1'b1;
		start_x <= sx;
		start_y <= sy;
		end_x   <= ex;
		end_y   <= ey;
		glyph   <= g;
		paint   <= p;
		do @(posedge clk); while (busy);
	endtask

	// write one register, then read it back
	task automatic write_reg(logic sel, logic [AREA_W-1:0] val);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		paddr   <= {sel, 2'b00};
		pwdata  <= {25'($urandom()), val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_area(logic [AREA_W-1:0] w, logic [AREA_W-1:0] h);
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		write_reg(REG_AREA_WIDTH, w);
		write_reg(REG_AREA_HEIGHT, h);
	endtask

	initial begin
		int ph, n, kind;
		logic [COORD_W-1:0] ax, ay, bx, by;
		logic [AREA_W-1:0] cols[6];
		logic [AREA_W-1:0] rows[6];

		cols = '{7'd0, 7'd127, 7'd1, 7'($urandom_range(2, 63)), 7'd64,
			7'($urandom_range(0, 127))};
		rows = '{7'd127, 7'd0, 7'd1, 7'($urandom_range(2, 63)), 7'd1,
			7'($urandom_range(0, 127))};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed lines at the reset area
		send_line(0, 0, 0, 0, 16'h0000, 8'h00);
		send_line(63, 63, 63, 63, 16'hFFFF, 8'hFF);
		send_line(0, 0, 63, 63, 16'hA5A5, 8'h5A);
		send_line(63, 63, 0, 0, 16'h5A5A, 8'hA5);
		send_line(0, 63, 63, 0, 16'h1234, 8'h01);
		send_line(63, 0, 0, 63, 16'h8000, 8'h80);
		send_line(0, 5, 63, 5, 16'hFFFF, 8'h00);
		send_line(63, 40, 0, 40, 16'h0001, 8'hFF);
		send_line(7, 0, 7, 63, 16'h7FFF, 8'h7F);
		send_line(30, 63, 30, 0, 16'h0F0F, 8'hF0);
		send_line(2, 10, 60, 30, 16'hBEEF, 8'h3C);
		send_line(60, 30, 2, 10, 16'hCAFE, 8'hC3);
		send_line(10, 2, 30, 60, 16'h00FF, 8'h11);
		send_line(30, 60, 10, 2, 16'hFF00, 8'h22);
		send_line(5, 50, 45, 20, 16'h4321, 8'h44);
		send_line(20, 55, 40, 3, 16'h9999, 8'h99);
		send_line(1, 1, 3, 2, 16'h2222, 8'h33);
		send_line(1, 1, 2, 3, 16'h3333, 8'h44);

		for (ph = 0; ph < 6; ph++) begin
			set_area(cols[ph], rows[ph]);
			idle_pct = (ph < 2) ? 28 : (ph < 4) ? 76 : 0;
			for (n = 0; n < PHASE_LINES; n++) begin
				kind = $urandom_range(99);
				ax = COORD_W'($urandom());
				ay = COORD_W'($urandom());
				if (kind < 55) begin
					bx = COORD_W'($urandom());
					by = COORD_W'($urandom());
				end else if (kind < 80) begin
					// short lines, wrapping near the edges
					bx = ax + COORD_W'($urandom_range(0, 8)) - COORD_W'(4);
					by = ay + COORD_W'($urandom_range(0, 8)) - COORD_W'(4);
				end else if (kind < 88) begin
					bx = COORD_W'($urandom());
					by = ay;
				end else if (kind < 95) begin
					bx = ax;
					by = COORD_W'($urandom());
				end else begin
					bx = ax;
					by = ay;
				end
				send_line(ax, ay, bx, by, GLYPH_W'($urandom()), PAINT_W'($urandom()));
			end
		end

		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (failures == 0)
			$display("line_rasterizer test passed");
		else
			$display("line_rasterizer test failed");
		$finish;
	end

endmodule
